// ===== rtl/cmean_pkg.sv =====
// Package for the multichannel block mean: default widths, channel count,
// controller state and lane operation codes, and the controller-to-datapath struct.
// No dependencies.
package cmean_pkg;

  localparam int NUM_CH          = 12;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_STORE
  } state_t;

  typedef enum logic [2:0] {
    LOP_HOLD,
    LOP_LOAD,
    LOP_ADD,
    LOP_DIV,
    LOP_CLEAR
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     out_load;
  } ctl_t;

endpackage

// ===== rtl/cmean_if.sv =====
// Handshake channel interfaces of the multichannel block mean: frame input,
// mean result output and mean count configuration write.
// Depends on cmean_pkg for default widths.
interface cmean_in_if #(
  parameter int SAMPLE_BITS = cmean_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_ch0;
  logic [SAMPLE_BITS-1:0] sample_ch1;
  logic [SAMPLE_BITS-1:0] sample_ch2;
  logic [SAMPLE_BITS-1:0] sample_ch3;
  logic [SAMPLE_BITS-1:0] sample_ch4;
  logic [SAMPLE_BITS-1:0] sample_ch5;
  logic [SAMPLE_BITS-1:0] sample_ch6;
  logic [SAMPLE_BITS-1:0] sample_ch7;
  logic [SAMPLE_BITS-1:0] sample_ch8;
  logic [SAMPLE_BITS-1:0] sample_ch9;
  logic [SAMPLE_BITS-1:0] sample_ch10;
  logic [SAMPLE_BITS-1:0] sample_ch11;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
           sample_ch6, sample_ch7, sample_ch8, sample_ch9, sample_ch10, sample_ch11,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
           sample_ch6, sample_ch7, sample_ch8, sample_ch9, sample_ch10, sample_ch11,
    output ready
  );
endinterface

interface cmean_out_if #(
  parameter int SAMPLE_BITS = cmean_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] mean_ch0;
  logic [SAMPLE_BITS-1:0] mean_ch1;
  logic [SAMPLE_BITS-1:0] mean_ch2;
  logic [SAMPLE_BITS-1:0] mean_ch3;
  logic [SAMPLE_BITS-1:0] mean_ch4;
  logic [SAMPLE_BITS-1:0] mean_ch5;
  logic [SAMPLE_BITS-1:0] mean_ch6;
  logic [SAMPLE_BITS-1:0] mean_ch7;
  logic [SAMPLE_BITS-1:0] mean_ch8;
  logic [SAMPLE_BITS-1:0] mean_ch9;
  logic [SAMPLE_BITS-1:0] mean_ch10;
  logic [SAMPLE_BITS-1:0] mean_ch11;

  modport source (
    output valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3, mean_ch4, mean_ch5,
           mean_ch6, mean_ch7, mean_ch8, mean_ch9, mean_ch10, mean_ch11,
    input  ready
  );
  modport sink (
    input  valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3, mean_ch4, mean_ch5,
           mean_ch6, mean_ch7, mean_ch8, mean_ch9, mean_ch10, mean_ch11,
    output ready
  );
endinterface

interface cmean_cfg_if #(
  parameter int COUNT_BITS = cmean_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] mean_count;

  modport source (output valid, mean_count, input ready);
  modport sink (input valid, mean_count, output ready);
endinterface

// ===== rtl/cmean_lane.sv =====
// One channel lane: running sum register with a bit-serial adder and a
// bit-serial restoring divider that leaves the quotient in the sum register.
// Depends on cmean_pkg for the lane operation codes.
module cmean_lane #(
  parameter int SAMPLE_BITS = cmean_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cmean_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmean_pkg::lane_op_t    op,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [COUNT_BITS-1:0]  divisor,
  output logic [SAMPLE_BITS-1:0] mean
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  logic [SUM_BITS-1:0]    sum_r;
  logic [SAMPLE_BITS-1:0] samp_r;
  logic                   carry_r;
  logic [COUNT_BITS-1:0]  rem_r;

  logic                  add_bit;
  logic                  add_carry;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  q_bit;

  // The sum rotates right LSB first; the sample shifts out beside it.
  assign add_bit   = sum_r[0] ^ samp_r[0] ^ carry_r;
  assign add_carry = (sum_r[0] & samp_r[0]) | (carry_r & (sum_r[0] ^ samp_r[0]));

  // Division shifts the sum left MSB first into the partial remainder.
  assign trial = {rem_r, sum_r[SUM_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign q_bit = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      samp_r  <= '0;
      carry_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      case (op)
        cmean_pkg::LOP_LOAD: begin
          samp_r  <= sample;
          carry_r <= 1'b0;
          rem_r   <= '0;
        end
        cmean_pkg::LOP_ADD: begin
          sum_r   <= {add_bit, sum_r[SUM_BITS-1:1]};
          samp_r  <= {1'b0, samp_r[SAMPLE_BITS-1:1]};
          carry_r <= add_carry;
        end
        cmean_pkg::LOP_DIV: begin
          sum_r <= {sum_r[SUM_BITS-2:0], q_bit};
          rem_r <= q_bit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        end
        cmean_pkg::LOP_CLEAR: begin
          sum_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // After the division the mean always fits in the low sample bits.
  assign mean = sum_r[SAMPLE_BITS-1:0];

endmodule

// ===== rtl/cmean_ctrl.sv =====
// Sequencer of the multichannel block mean: handshakes, frame counter, mean
// count register and the bit counter that paces the serial add and divide.
// Depends on cmean_pkg for state, lane operation and control types.
module cmean_ctrl #(
  parameter int SAMPLE_BITS = cmean_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cmean_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  out_free,
  output cmean_pkg::ctl_t       ctl,
  output logic [COUNT_BITS-1:0] divisor
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam int CNT_W    = $clog2(SUM_BITS);

  cmean_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] mcount_r;
  logic                  emit_r;

  logic                  last_bit;
  logic                  in_acc;
  logic                  cfg_acc;
  logic                  store_go;
  logic [COUNT_BITS-1:0] target;
  logic [COUNT_BITS-1:0] count_inc;

  assign last_bit  = (cnt_r == CNT_W'(SUM_BITS - 1));
  assign in_acc    = in_valid & in_ready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign store_go  = (state_r == cmean_pkg::ST_STORE) & out_free;
  assign target    = (mcount_r == '0) ? COUNT_BITS'(1) : mcount_r;
  assign count_inc = count_r + COUNT_BITS'(1);
  assign divisor   = count_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cmean_pkg::ST_IDLE: begin
        if (!cfg_valid && in_valid) state_nxt = cmean_pkg::ST_ADD;
      end
      cmean_pkg::ST_ADD: begin
        if (last_bit) state_nxt = emit_r ? cmean_pkg::ST_DIV : cmean_pkg::ST_IDLE;
      end
      cmean_pkg::ST_DIV: begin
        if (last_bit) state_nxt = cmean_pkg::ST_STORE;
      end
      cmean_pkg::ST_STORE: begin
        if (out_free) state_nxt = cmean_pkg::ST_IDLE;
      end
      default: state_nxt = cmean_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cfg_ready    = 1'b0;
    ctl.op       = cmean_pkg::LOP_HOLD;
    ctl.out_load = 1'b0;
    unique case (state_r)
      cmean_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) ctl.op = cmean_pkg::LOP_CLEAR;
        else if (in_valid) ctl.op = cmean_pkg::LOP_LOAD;
      end
      cmean_pkg::ST_ADD: ctl.op = cmean_pkg::LOP_ADD;
      cmean_pkg::ST_DIV: ctl.op = cmean_pkg::LOP_DIV;
      cmean_pkg::ST_STORE: begin
        if (out_free) begin
          ctl.op       = cmean_pkg::LOP_CLEAR;
          ctl.out_load = 1'b1;
        end
      end
      default: ctl.op = cmean_pkg::LOP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cmean_pkg::ST_IDLE;
      cnt_r    <= '0;
      count_r  <= '0;
      mcount_r <= COUNT_BITS'(1);
      emit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == cmean_pkg::ST_ADD || state_r == cmean_pkg::ST_DIV) && !last_bit) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (cfg_acc) begin
        mcount_r <= cfg_data;
        count_r  <= '0;
      end else if (in_acc) begin
        count_r <= count_inc;
        emit_r  <= (count_inc >= target);
      end else if (store_go) begin
        count_r <= '0;
      end
    end
  end

endmodule

// ===== rtl/multichannel_block_mean.sv =====
// Multichannel block mean: averages blocks of frames per channel and emits truncated means.
// Depends on cmean_pkg, the channel interfaces in cmean_if, cmean_ctrl and cmean_lane.
//
// Each accepted frame is added into twelve 24-bit running sums by bit-serial adders, one
// bit per cycle. The frame that completes a block is followed by a bit-serial restoring
// division in every lane, after which the means move into the output register once it is free.
// The output register holds a finished result while the next frame is taken in. Writing the
// mean count clears the sums and the frame count; a mean count of zero acts as one.
module multichannel_block_mean #(
  parameter int SAMPLE_BITS = cmean_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cmean_pkg::COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cmean_in_if.sink   in_bus,
  cmean_out_if.source out_bus,
  cmean_cfg_if.sink  cfg_bus
);

  localparam int NCH = cmean_pkg::NUM_CH;

  cmean_pkg::ctl_t       ctl;
  logic [COUNT_BITS-1:0] divisor;
  logic                  out_free;
  logic                  out_valid_r;
  logic [SAMPLE_BITS-1:0] samples [NCH];
  logic [SAMPLE_BITS-1:0] lane_mean [NCH];
  logic [SAMPLE_BITS-1:0] mean_r [NCH];

  assign samples[0]  = in_bus.sample_ch0;
  assign samples[1]  = in_bus.sample_ch1;
  assign samples[2]  = in_bus.sample_ch2;
  assign samples[3]  = in_bus.sample_ch3;
  assign samples[4]  = in_bus.sample_ch4;
  assign samples[5]  = in_bus.sample_ch5;
  assign samples[6]  = in_bus.sample_ch6;
  assign samples[7]  = in_bus.sample_ch7;
  assign samples[8]  = in_bus.sample_ch8;
  assign samples[9]  = in_bus.sample_ch9;
  assign samples[10] = in_bus.sample_ch10;
  assign samples[11] = in_bus.sample_ch11;

  assign out_free = !out_valid_r || out_bus.ready;

  cmean_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .cfg_valid (cfg_bus.valid),
    .cfg_ready (cfg_bus.ready),
    .cfg_data  (cfg_bus.mean_count),
    .out_free  (out_free),
    .ctl       (ctl),
    .divisor   (divisor)
  );

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    cmean_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (ctl.op),
      .sample  (samples[g]),
      .divisor (divisor),
      .mean    (lane_mean[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      mean_r <= lane_mean;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.mean_ch0  = mean_r[0];
  assign out_bus.mean_ch1  = mean_r[1];
  assign out_bus.mean_ch2  = mean_r[2];
  assign out_bus.mean_ch3  = mean_r[3];
  assign out_bus.mean_ch4  = mean_r[4];
  assign out_bus.mean_ch5  = mean_r[5];
  assign out_bus.mean_ch6  = mean_r[6];
  assign out_bus.mean_ch7  = mean_r[7];
  assign out_bus.mean_ch8  = mean_r[8];
  assign out_bus.mean_ch9  = mean_r[9];
  assign out_bus.mean_ch10 = mean_r[10];
  assign out_bus.mean_ch11 = mean_r[11];

endmodule

// ===== rtl/cmean_checker.sv =====
// Port-level checks of the multichannel block mean, attached to the top level by bind.
// Depends only on the top level's channel signals.
module cmean_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_mean0,
  input logic cfg_valid,
  input logic cfg_ready
);

  // An accepted frame keeps the input side busy during its serial add.
  a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a frame transaction");

  // A result cannot appear in the cycle after a frame transaction.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too soon after a frame transaction");

  // A configuration write and a frame never complete together.
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !(in_valid && in_ready))
    else $error("configuration and frame transactions in the same cycle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_mean0)))
    else $error("stalled result changed");

endmodule

bind multichannel_block_mean cmean_checker u_cmean_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_mean0 (out_bus.mean_ch0[0]),
  .cfg_valid (cfg_bus.valid),
  .cfg_ready (cfg_bus.ready)
);

// ===== tb/tb_multichannel_block_mean.sv =====
// Self-checking testbench for multichannel_block_mean: directed frames, then random blocks.
// A local block-mean predictor fills the queue of expected means, and a monitor checks them.
// Depends on cmean_pkg, the channel interfaces in cmean_if and the RTL top level.
module tb_multichannel_block_mean;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH = cmean_pkg::NUM_CH;
  localparam int SB = cmean_pkg::SAMPLE_BITS_DEF;
  localparam int CB = cmean_pkg::COUNT_BITS_DEF;

  localparam int RANDOM_ITEMS  = 950;
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int IDLE_PERCENT  = 26;
  localparam int PRESSURE_PHASE = 3;
  localparam int PAUSE_PHASE   = 5;

  typedef logic [CH-1:0][SB-1:0] chan_vec_t;

  typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [CB-1:0] count_val;
    chan_vec_t     samples;
    bit            typed;
    chan_vec_t     want;
  } dir_row_t;

  localparam int N_DIR = 17;

  // Rows with typed means all complete a block; the rest are left to the predictor.
  dir_row_t dir_tab [N_DIR] = '{
    '{ROW_FRAME, 8'd0, {12{16'h0000}}, 1'b1, {12{16'h0000}}},
    '{ROW_FRAME, 8'd0, {12{16'hFFFF}}, 1'b1, {12{16'hFFFF}}},
    '{ROW_FRAME, 8'd0, {6{16'hAAAA, 16'h5555}}, 1'b1, {6{16'hAAAA, 16'h5555}}},
    '{ROW_FRAME, 8'd0,
      {16'h0800, 16'h0400, 16'h0200, 16'h0100, 16'h0080, 16'h0040,
       16'h0020, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001}, 1'b1,
      {16'h0800, 16'h0400, 16'h0200, 16'h0100, 16'h0080, 16'h0040,
       16'h0020, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001}},
    '{ROW_FRAME, 8'd0, {12{16'h8000}}, 1'b1, {12{16'h8000}}},
    '{ROW_CFG, 8'd0, '0, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {6{16'hFFFF, 16'h0000}}, 1'b1, {6{16'hFFFF, 16'h0000}}},
    '{ROW_FRAME, 8'd0, {12{16'h0001}}, 1'b1, {12{16'h0001}}},
    '{ROW_CFG, 8'd2, '0, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {12{16'hFFFF}}, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {12{16'h0000}}, 1'b1, {12{16'h7FFF}}},
    '{ROW_CFG, 8'd3, '0, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {12{16'h1234}}, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {12{16'hFEDC}}, 1'b0, '0},
    // Rewriting the count throws away the two frames above.
    '{ROW_CFG, 8'd3, '0, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {6{16'h0064, 16'h00C8}}, 1'b0, '0},
    '{ROW_FRAME, 8'd0, {6{16'h0007, 16'hFFFF}}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  cmean_in_if  in_bus ();
  cmean_out_if out_bus ();
  cmean_cfg_if cfg_bus ();

  multichannel_block_mean u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [SB+CB-1:0] lane_sum [CH];
  logic [CB-1:0]    frames_in_block;
  logic [CB-1:0]    block_len;

  chan_vec_t pending_means [$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        no_idle = 1'b0;
  bit        hold_results = 1'b0;

  function automatic void load_mean_count(input logic [CB-1:0] value);
    block_len = value;
    frames_in_block = '0;
    for (int ch = 0; ch < CH; ch++) lane_sum[ch] = '0;
  endfunction

  function automatic bit accumulate_frame(input chan_vec_t frame, output chan_vec_t means);
    logic [CB-1:0]    target;
    logic [SB+CB-1:0] quot;
    target = (block_len == '0) ? CB'(1) : block_len;
    frames_in_block = frames_in_block + 1'b1;
    for (int ch = 0; ch < CH; ch++) lane_sum[ch] = lane_sum[ch] + frame[ch];
    means = '0;
    if (frames_in_block < target) return 1'b0;
    for (int ch = 0; ch < CH; ch++) begin
      quot = lane_sum[ch] / frames_in_block;
      means[ch] = quot[SB-1:0];
    end
    frames_in_block = '0;
    for (int ch = 0; ch < CH; ch++) lane_sum[ch] = '0;
    return 1'b1;
  endfunction

  function automatic chan_vec_t rand_frame();
    chan_vec_t f;
    for (int ch = 0; ch < CH; ch++) begin
      case ($urandom_range(9))
        0: f[ch] = '0;
        1: f[ch] = '1;
        2: f[ch] = SB'($urandom_range(255));
        default: f[ch] = SB'($urandom_range(65535));
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(input chan_vec_t f, input bit typed, input chan_vec_t want);
    chan_vec_t m;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid       <= 1'b1;
    in_bus.sample_ch0  <= f[0];
    in_bus.sample_ch1  <= f[1];
    in_bus.sample_ch2  <= f[2];
    in_bus.sample_ch3  <= f[3];
    in_bus.sample_ch4  <= f[4];
    in_bus.sample_ch5  <= f[5];
    in_bus.sample_ch6  <= f[6];
    in_bus.sample_ch7  <= f[7];
    in_bus.sample_ch8  <= f[8];
    in_bus.sample_ch9  <= f[9];
    in_bus.sample_ch10 <= f[10];
    in_bus.sample_ch11 <= f[11];
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (accumulate_frame(f, m)) pending_means.push_back(typed ? want : m);
  endtask

  // Stop offering frames and let every block in flight finish.
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mean_count(input logic [CB-1:0] value);
    settle_block();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.mean_count <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    load_mean_count(value);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    chan_vec_t got;
    chan_vec_t exp_means;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.mean_ch11, out_bus.mean_ch10, out_bus.mean_ch9, out_bus.mean_ch8,
             out_bus.mean_ch7, out_bus.mean_ch6, out_bus.mean_ch5, out_bus.mean_ch4,
             out_bus.mean_ch3, out_bus.mean_ch2, out_bus.mean_ch1, out_bus.mean_ch0};
      if (pending_means.size() == 0) begin
        $display("%0t: result transaction with none expected, means %h", $time, got);
        mismatches++;
      end else begin
        exp_means = pending_means.pop_front();
        for (int ch = 0; ch < CH; ch++) begin
          if (got[ch] !== exp_means[ch]) begin
            $display("%0t: mean_ch%0d expected %h actual %h", $time, ch, exp_means[ch],
                     got[ch]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int            random_sent;
    int            phase;
    int            n_frames;
    logic [CB-1:0] cnt;
    int            pick;

    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.sample_ch0  <= '0;
    in_bus.sample_ch1  <= '0;
    in_bus.sample_ch2  <= '0;
    in_bus.sample_ch3  <= '0;
    in_bus.sample_ch4  <= '0;
    in_bus.sample_ch5  <= '0;
    in_bus.sample_ch6  <= '0;
    in_bus.sample_ch7  <= '0;
    in_bus.sample_ch8  <= '0;
    in_bus.sample_ch9  <= '0;
    in_bus.sample_ch10 <= '0;
    in_bus.sample_ch11 <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.mean_count <= '0;
    load_mean_count(CB'(1));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        write_mean_count(dir_tab[r].count_val);
      end else begin
        send_frame(dir_tab[r].samples, dir_tab[r].typed, dir_tab[r].want);
      end
    end

    // Longest block at full scale: the running sums reach their largest value.
    write_mean_count('1);
    for (int i = 0; i < 257; i++) send_frame({CH{16'hFFFF}}, 1'b0, '0);
    random_sent = 257;

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60) cnt = CB'($urandom_range(1, 4));
      else if (pick < 75) cnt = CB'($urandom_range(5, 16));
      else if (pick < 88) cnt = '0;
      else cnt = CB'($urandom_range(17, 60));
      if (phase == PRESSURE_PHASE) cnt = CB'(1);
      write_mean_count(cnt);
      n_frames = ((cnt == '0) ? 1 : int'(cnt)) * $urandom_range(1, 4) + $urandom_range(0, 2);
      if (phase == PRESSURE_PHASE) begin
        // The result side stalls while frames keep coming, so the block backs up.
        n_frames = 12;
        hold_results = 1'b1;
      end
      if (n_frames > RANDOM_ITEMS - random_sent) n_frames = RANDOM_ITEMS - random_sent;
      for (int i = 0; i < n_frames; i++) begin
        no_idle = (random_sent >= 450) && (random_sent < 600);
        if (i == n_frames / 2 && (phase == PAUSE_PHASE || $urandom_range(7) == 0)) begin
          in_bus.valid <= 1'b0;
          @(posedge clk);
          while (pending_means.size() != 0) @(posedge clk);
        end
        send_frame(rand_frame(), 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    no_idle = 1'b0;
    settle_block();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
